@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the event domain controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/edc_pkg.sv @@
// Types, codes and widths of the event domain controller.
package edc_pkg;

    localparam int NUM_NOTIFY_DEF = 8;
    localparam int OWNER_BITS_DEF = 8;

    localparam int CMD_W      = 4;
    localparam int ID_W       = 8;
    localparam int NIDX_W     = 4;
    localparam int SEQ_W      = 64;
    localparam int DEPTH_W    = 32;
    localparam int STAT_W     = 3;
    localparam int TIDX_W     = 3;
    localparam int CNT_W      = 64;

    localparam int IN_FIELDS_W  = ID_W + ID_W + NIDX_W + SEQ_W;
    localparam int OUT_FIELDS_W = STAT_W + 1 + TIDX_W + CNT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W    = CMD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT        = 4'd0,
        CMD_CAN_ENTER   = 4'd1,
        CMD_ENTER       = 4'd2,
        CMD_RELEASE     = 4'd3,
        CMD_HANDOFF     = 4'd4,
        CMD_FINISH      = 4'd5,
        CMD_ABORT       = 4'd6,
        CMD_PENDING     = 4'd7,
        CMD_CLOSE       = 4'd8,
        CMD_REOPEN      = 4'd9,
        CMD_SHOULD_WAIT = 4'd10,
        CMD_NOTIFY      = 4'd11,
        CMD_MASK        = 4'd12,
        CMD_UNMASK      = 4'd13,
        CMD_TAKE        = 4'd14,
        CMD_RETURN      = 4'd15
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_BUSY     = 3'd2,
        ST_CLOSED   = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // Packed with the first field in the highest bits and the last field in the lowest bits.
    typedef struct packed {
        logic [SEQ_W-1:0]  seen_sequence;
        logic [NIDX_W-1:0] notify_index;
        logic [ID_W-1:0]   next_owner;
        logic [ID_W-1:0]   owner_id;
    } in_fields_t;

    typedef struct packed {
        logic [CNT_W-1:0]  taken_count;
        logic [TIDX_W-1:0] taken_index;
        logic              answer_flag;
        status_t           status;
    } out_fields_t;

endpackage

@@ rtl/core/event_domain_controller.sv @@
// Event domain controller: owner tracking, notification counters and irq masking.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+---------------------------------------
//   s_axis   | s_axis_tvalid, s_axis_tready | tuser: command; tdata: ids, index, seq
//   m_axis   | m_axis_tvalid, m_axis_tready | tdata: status, flag, index, count
//
// One command enters per cycle while s_axis_tready is high. It waits in the input
// register and moves to the result register once that register is empty or being
// read, and its result transaction is offered from the result register.
// All state checks and updates for a command happen in the cycle in which it
// moves from the input register to the result register; a priority encoder over the
// pending counters sets the longest path there.
// rst_n clears every control and state register asynchronously; no clearing pass.
// A stalled result register holds the command in the input register, and the slave
// side stops accepting only when both registers are full.
module event_domain_controller #(
    parameter int NUM_NOTIFY = edc_pkg::NUM_NOTIFY_DEF,
    parameter int OWNER_BITS = edc_pkg::OWNER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: owner_id[7:0], next_owner[15:8], notify_index[19:16],
    // seen_sequence[83:20], zero pad[87:84].
    input  logic [edc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser from bit 0: command[3:0].
    input  logic [edc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: status[2:0], answer_flag[3], taken_index[6:4],
    // taken_count[70:7], zero pad[71].
    output logic [edc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W = (NUM_NOTIFY > 1) ? $clog2(NUM_NOTIFY) : 1;

    // Pipeline registers.
    logic                  in_valid_reg;
    edc_pkg::cmd_t         cmd_reg;
    edc_pkg::in_fields_t   fields_reg;
    logic                  out_valid_reg;
    edc_pkg::out_fields_t  out_reg;
    edc_pkg::out_fields_t  out_next;

    // Controller state.
    logic [OWNER_BITS-1:0]       owner_reg, owner_next;
    logic                        handoff_done_reg, handoff_done_next;
    logic                        accepting_reg, accepting_next;
    logic [edc_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [edc_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [edc_pkg::CNT_W-1:0]   pend_reg  [NUM_NOTIFY];
    logic [edc_pkg::CNT_W-1:0]   pend_next [NUM_NOTIFY];

    logic s_accept;
    logic advance;
    logic fire;

    // Decoded operands and shared terms.
    logic [OWNER_BITS-1:0]     who;
    logic [OWNER_BITS-1:0]     nxt;
    logic                      can_enter;
    logic                      idx_ok;
    logic [IDX_W-1:0]          nidx;
    logic [edc_pkg::CNT_W-1:0] pend_sel;
    logic [NUM_NOTIFY-1:0]     pend_nz;
    logic [NUM_NOTIFY-1:0]     low_onehot;
    logic                      any_pend;
    logic [IDX_W-1:0]          take_idx;
    logic [edc_pkg::CNT_W-1:0] take_cnt;
    logic                      notify_ok;
    logic                      take_ok;

    // The result register frees up when it is empty or being read this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(edc_pkg::OUT_DATA_W - edc_pkg::OUT_FIELDS_W){1'b0}}, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg    <= edc_pkg::cmd_t'(s_axis_tuser);
            fields_reg <= edc_pkg::in_fields_t'(s_axis_tdata[edc_pkg::IN_FIELDS_W-1:0]);
        end
        if (fire)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg        <= '0;
            handoff_done_reg <= 1'b1;
            accepting_reg    <= 1'b1;
            depth_reg        <= '0;
            seq_reg          <= '0;
            for (int i = 0; i < NUM_NOTIFY; i++)
                pend_reg[i] <= '0;
        end
        else if (fire)
        begin
            owner_reg        <= owner_next;
            handoff_done_reg <= handoff_done_next;
            accepting_reg    <= accepting_next;
            depth_reg        <= depth_next;
            seq_reg          <= seq_next;
            for (int i = 0; i < NUM_NOTIFY; i++)
                pend_reg[i] <= pend_next[i];
        end
    end

    // Owner ids are reduced to OWNER_BITS bits before any compare.
    assign who       = OWNER_BITS'(fields_reg.owner_id);
    assign nxt       = OWNER_BITS'(fields_reg.next_owner);
    assign can_enter = (owner_reg == '0) || ((owner_reg == who) && handoff_done_reg);

    assign idx_ok = ({1'b0, fields_reg.notify_index} < (edc_pkg::NIDX_W + 1)'(NUM_NOTIFY));
    assign nidx   = fields_reg.notify_index[IDX_W-1:0];

    // Lowest nonzero counter wins the take; the one-hot mask selects its count.
    always_comb
    begin
        for (int i = 0; i < NUM_NOTIFY; i++)
            pend_nz[i] = (pend_reg[i] != '0);
        any_pend   = |pend_nz;
        low_onehot = pend_nz & (~pend_nz + NUM_NOTIFY'(1));
        take_idx   = '0;
        take_cnt   = '0;
        pend_sel   = '0;
        for (int i = 0; i < NUM_NOTIFY; i++)
        begin
            if (low_onehot[i])
            begin
                take_idx = take_idx | IDX_W'(i);
                take_cnt = take_cnt | pend_reg[i];
            end
            if (nidx == IDX_W'(i))
                pend_sel = pend_reg[i];
        end
    end

    assign notify_ok = idx_ok && accepting_reg && (seq_reg != '1) && (pend_sel != '1);
    assign take_ok   = (depth_reg == '0) && any_pend;

    always_comb
    begin
        owner_next        = owner_reg;
        handoff_done_next = handoff_done_reg;
        accepting_next    = accepting_reg;
        depth_next        = depth_reg;
        seq_next          = seq_reg;
        for (int i = 0; i < NUM_NOTIFY; i++)
            pend_next[i] = pend_reg[i];
        out_next             = '0;
        out_next.status      = edc_pkg::ST_OK;

        case (cmd_reg)
            edc_pkg::CMD_INIT:
            begin
                owner_next        = '0;
                handoff_done_next = 1'b1;
                accepting_next    = 1'b1;
                depth_next        = '0;
                seq_next          = '0;
                for (int i = 0; i < NUM_NOTIFY; i++)
                    pend_next[i] = '0;
            end
            edc_pkg::CMD_CAN_ENTER:
                out_next.answer_flag = can_enter;
            edc_pkg::CMD_ENTER:
            begin
                if (who == '0)
                    out_next.status = edc_pkg::ST_INVALID;
                else if (!can_enter)
                    out_next.status = edc_pkg::ST_BUSY;
                else
                    owner_next = who;
            end
            edc_pkg::CMD_RELEASE:
            begin
                owner_next        = '0;
                handoff_done_next = 1'b1;
            end
            edc_pkg::CMD_HANDOFF:
            begin
                if ((who == '0) || (nxt == '0) || (who == nxt) ||
                    (owner_reg != who) || !handoff_done_reg)
                    out_next.status = edc_pkg::ST_INVALID;
                else
                begin
                    handoff_done_next = 1'b0;
                    owner_next        = nxt;
                end
            end
            edc_pkg::CMD_FINISH:
                handoff_done_next = 1'b1;
            edc_pkg::CMD_ABORT:
            begin
                owner_next        = who;
                handoff_done_next = 1'b1;
            end
            edc_pkg::CMD_PENDING:
                out_next.answer_flag = any_pend;
            edc_pkg::CMD_CLOSE:
            begin
                if ((owner_reg != '0) || (depth_reg != '0) || any_pend)
                    out_next.status = edc_pkg::ST_BUSY;
                else
                    accepting_next = 1'b0;
            end
            edc_pkg::CMD_REOPEN:
                accepting_next = 1'b1;
            edc_pkg::CMD_SHOULD_WAIT:
                out_next.answer_flag = (seq_reg == fields_reg.seen_sequence) && !any_pend;
            edc_pkg::CMD_NOTIFY:
            begin
                if (!idx_ok)
                    out_next.status = edc_pkg::ST_INVALID;
                else if (!accepting_reg)
                    out_next.status = edc_pkg::ST_CLOSED;
                else if (!notify_ok)
                    out_next.status = edc_pkg::ST_OVERFLOW;
                else
                begin
                    seq_next = seq_reg + edc_pkg::SEQ_W'(1);
                    for (int i = 0; i < NUM_NOTIFY; i++)
                        if (nidx == IDX_W'(i))
                            pend_next[i] = pend_reg[i] + edc_pkg::CNT_W'(1);
                end
            end
            edc_pkg::CMD_MASK:
            begin
                if (depth_reg == '1)
                    out_next.status = edc_pkg::ST_OVERFLOW;
                else
                    depth_next = depth_reg + edc_pkg::DEPTH_W'(1);
            end
            edc_pkg::CMD_UNMASK:
            begin
                if (depth_reg == '0)
                    out_next.status = edc_pkg::ST_INVALID;
                else
                begin
                    out_next.answer_flag = (depth_reg == edc_pkg::DEPTH_W'(1));
                    depth_next           = depth_reg - edc_pkg::DEPTH_W'(1);
                end
            end
            edc_pkg::CMD_TAKE:
            begin
                if (take_ok)
                begin
                    out_next.answer_flag = 1'b1;
                    out_next.taken_index = edc_pkg::TIDX_W'(take_idx);
                    out_next.taken_count = take_cnt;
                    depth_next           = edc_pkg::DEPTH_W'(1);
                    for (int i = 0; i < NUM_NOTIFY; i++)
                        if (low_onehot[i])
                            pend_next[i] = '0;
                end
            end
            edc_pkg::CMD_RETURN:
            begin
                if (depth_reg == edc_pkg::DEPTH_W'(1))
                begin
                    depth_next           = '0;
                    out_next.answer_flag = 1'b1;
                end
            end
            default:
                out_next.status = edc_pkg::ST_OK;
        endcase
    end

endmodule

@@ rtl/core/edc_checker.sv @@
// Port-level checker for the event domain controller, bound to the top level.
`include "assert_macros.svh"

module edc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [edc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic [edc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [edc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result transaction stays offered with its data unchanged.
    `EDC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result transaction dropped or changed while stalled")

    // The input side only stalls when both pipeline registers are full and blocked.
    `EDC_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled while the result side could move")

    // A drained count only comes with a successful take.
    `EDC_ASSERT_IMP(a_take_count, m_axis_tvalid && (m_axis_tdata[70:7] != 64'd0), (m_axis_tdata[3] == 1'b1) && (m_axis_tdata[2:0] == edc_pkg::ST_OK), "taken count without a successful take")

    // A nonzero taken index always comes with a nonzero drained count.
    `EDC_ASSERT_IMP(a_take_index, m_axis_tvalid && (m_axis_tdata[6:4] != 3'd0), m_axis_tdata[70:7] != 64'd0, "taken index without a drained count")

endmodule

bind event_domain_controller edc_checker u_edc_checker (.*);
